/* rtl/core/b64u_pkg.sv */
// Shared types, constants and the sextet-to-character map for the base64url encoder.
// No dependencies.
package b64u_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } t_phase;

    // One accepted byte's worth of output characters.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;  // index of the entry's last valid char
        logic            fin;       // last char of the entry ends the message
    } t_entry;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] r;
        case (v) inside
            [6'd0:6'd25]:  r = 8'(CH_UP_A + {2'b00, v});
            [6'd26:6'd51]: r = 8'(CH_LO_A + {2'b00, v} - 8'd26);
            [6'd52:6'd61]: r = 8'(CH_ZERO + {2'b00, v} - 8'd52);
            6'd62:         r = CH_DASH;
            default:       r = CH_UNDER;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/b64u_front.sv */
// Front end: accepts raw bytes, tracks group phase and carry bits, builds one queue entry
// per byte. Depends on b64u_pkg.
module b64u_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tvalid,
    output logic                o_tready,
    input  logic [7:0]          i_tdata,   // [7:0] data_byte
    input  logic                i_tlast,   // end_of_message
    output logic                o_push,
    output b64u_pkg::t_entry    o_entry,
    input  logic                i_full
);

    b64u_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_carry, n_carry;
    logic             w_acc;

    assign o_tready = !i_full;
    assign w_acc    = i_tvalid && !i_full;
    assign o_push   = w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64u_pkg::PH_0;
            r_carry <= 4'd0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

    always_comb begin
        o_entry          = '0;
        o_entry.chars[2] = b64u_pkg::CH_PAD;
        o_entry.chars[3] = b64u_pkg::CH_PAD;
        n_phase          = b64u_pkg::PH_0;
        n_carry          = 4'd0;
        case (r_phase)
            b64u_pkg::PH_1: begin
                o_entry.chars[0] = b64u_pkg::sextet_char({r_carry[1:0], i_tdata[7:4]});
                if (i_tlast) begin
                    o_entry.chars[1] = b64u_pkg::sextet_char({i_tdata[3:0], 2'b00});
                    o_entry.last_idx = 2'd2;
                    o_entry.fin      = 1'b1;
                end else begin
                    n_phase = b64u_pkg::PH_2;
                    n_carry = i_tdata[3:0];
                end
            end
            b64u_pkg::PH_2: begin
                o_entry.chars[0] = b64u_pkg::sextet_char({r_carry, i_tdata[7:6]});
                o_entry.chars[1] = b64u_pkg::sextet_char(i_tdata[5:0]);
                o_entry.last_idx = 2'd1;
                o_entry.fin      = i_tlast;
            end
            default: begin
                o_entry.chars[0] = b64u_pkg::sextet_char(i_tdata[7:2]);
                if (i_tlast) begin
                    o_entry.chars[1] = b64u_pkg::sextet_char({i_tdata[1:0], 4'b0000});
                    o_entry.last_idx = 2'd3;
                    o_entry.fin      = 1'b1;
                end else begin
                    n_phase = b64u_pkg::PH_1;
                    n_carry = {2'b00, i_tdata[1:0]};
                end
            end
        endcase
    end

endmodule

/* rtl/core/b64u_queue.sv */
// Small FIFO of character entries between the front and back ends.
// Depends on b64u_pkg.
module b64u_queue #(
    parameter int DEPTH = b64u_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64u_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output b64u_pkg::t_entry o_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64u_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr + 1'b1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : PW'(r_rd + 1'b1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= CW'(r_cnt + 1'b1);
            end else if (w_pop && !w_push) begin
                r_cnt <= CW'(r_cnt - 1'b1);
            end
        end
    end

endmodule

/* rtl/core/b64u_back.sv */
// Back end: unpacks queue entries and sends one character per transfer through an
// output register. Depends on b64u_pkg.
module b64u_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  b64u_pkg::t_entry i_entry,
    output logic             o_pop,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [7:0]       o_tdata,   // [7:0] out_char
    output logic             o_tlast    // final_char
);

    b64u_pkg::t_entry r_ent;
    logic             r_busy;
    logic [1:0]       r_idx;
    logic             r_oval;
    logic [7:0]       r_ochar;
    logic             r_olast;
    logic             w_adv, w_done;

    assign o_tvalid = r_oval;
    assign o_tdata  = r_ochar;
    assign o_tlast  = r_olast;

    // output register can take a new character this cycle
    assign w_adv  = !r_oval || i_tready;
    assign w_done = r_busy && (r_idx == r_ent.last_idx);
    assign o_pop  = w_adv && i_valid && (!r_busy || w_done);

    always_ff @(posedge i_clk) begin
        if (w_adv && r_busy) begin
            r_ochar <= r_ent.chars[r_idx];
            r_olast <= r_ent.fin && (r_idx == r_ent.last_idx);
        end
        if (o_pop) begin
            r_ent <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
            r_oval <= 1'b0;
        end else if (w_adv) begin
            r_oval <= r_busy;
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (w_done) begin
                r_busy <= 1'b0;
                r_idx  <= 2'd0;
            end else if (r_busy) begin
                r_idx <= 2'(r_idx + 1'b1);
            end
        end
    end

endmodule

/* rtl/core/base64url_stream_encoder.sv */
// Base64url stream encoder: one byte in per transfer, one character out per transfer.
// Path: byte -> entry queue -> back-end entry register -> output register.
// Throughput: one character per cycle from the back end while the receiver is ready;
// bytes are taken every cycle until the entry queue fills; then the single-character
// output register paces intake, as each byte yields one to four characters.
// Reset: synchronous active-low i_rst_n clears phase, carry, queue and output valid.
module base64url_stream_encoder #(
    parameter int QUEUE_DEPTH = b64u_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // end_of_message
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast    // final_char
);

    b64u_pkg::t_entry w_push_ent, w_pop_ent;
    logic             w_push, w_full, w_pop, w_qvalid;

    b64u_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tlast  (s_axis_tlast),
        .o_push   (w_push),
        .o_entry  (w_push_ent),
        .i_full   (w_full)
    );

    b64u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_ent),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_entry (w_pop_ent)
    );

    b64u_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_qvalid),
        .i_entry  (w_pop_ent),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

/* tb/sv/tb_base64url_stream_encoder.sv */
`timescale 1ns / 100ps
// Self-checking testbench for base64url_stream_encoder: directed and random message bytes in,
// predicted base64url characters compared against every output transfer. Depends on b64u_pkg.
module tb_base64url_stream_encoder;

    localparam int  N_RANDOM_BYTES = 250;
    localparam int  CYCLE_LIMIT    = 200000;
    localparam int  DRAIN_CYCLES   = 20;
    localparam int  HOLD_AFTER     = 80;    // bytes in before the long receiver hold-off
    localparam int  HOLD_CYCLES    = 400;

    localparam logic [7:0] ASC_UP_A  = "A";
    localparam logic [7:0] ASC_LO_A  = "a";
    localparam logic [7:0] ASC_DIG_0 = "0";
    localparam logic [7:0] ASC_DASH  = "-";
    localparam logic [7:0] ASC_UNDER = "_";
    localparam logic [7:0] ASC_PAD   = "=";

    typedef enum logic [1:0] {
        RX_ALWAYS  = 2'd0,
        RX_RANDOM  = 2'd1,
        RX_SPARSE  = 2'd2,
        RX_PATTERN = 2'd3
    } t_rx_mode;

    typedef struct {
        logic [7:0] data;
        logic       eom;
    } t_msg_byte;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
    } t_enc_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic       s_axis_tlast = 1'b0;    // end_of_message
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_char
    logic       m_axis_tlast;           // final_char

    t_msg_byte  msg_byte_q[$];
    t_enc_char  enc_char_q[$];

    b64u_pkg::t_phase enc_phase = b64u_pkg::PH_0;
    logic [3:0] enc_carry = 4'h0;

    int         err_cnt = 0;
    int         cyc_cnt = 0;
    int         bytes_in = 0;
    int         burst_left = 0;
    int         gap_left = 0;
    int         rx_cyc = 0;
    int         hold_left = 0;
    logic       hold_done = 1'b0;
    t_rx_mode   rx_mode = RX_ALWAYS;

    base64url_stream_encoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [7:0] b64url_char(input logic [5:0] v);
        if (v < 6'd26) return ASC_UP_A + 8'(v);
        if (v < 6'd52) return ASC_LO_A + 8'(v - 6'd26);
        if (v < 6'd62) return ASC_DIG_0 + 8'(v - 6'd52);
        if (v == 6'd62) return ASC_DASH;
        return ASC_UNDER;
    endfunction

    task automatic push_char(input logic [7:0] ch, input logic fin);
        t_enc_char e;
        e.ch  = ch;
        e.fin = fin;
        enc_char_q.push_back(e);
    endtask

    // Advances the group state by one byte and queues the characters it completes.
    task automatic encode_byte(input logic [7:0] b, input logic eom);
        case (enc_phase)
            b64u_pkg::PH_1: begin
                push_char(b64url_char({enc_carry[1:0], b[7:4]}), 1'b0);
                if (eom) begin
                    push_char(b64url_char({b[3:0], 2'b00}), 1'b0);
                    push_char(ASC_PAD, 1'b1);
                    enc_phase = b64u_pkg::PH_0;
                    enc_carry = 4'h0;
                end else begin
                    enc_phase = b64u_pkg::PH_2;
                    enc_carry = b[3:0];
                end
            end
            b64u_pkg::PH_2: begin
                push_char(b64url_char({enc_carry, b[7:6]}), 1'b0);
                push_char(b64url_char(b[5:0]), eom);
                enc_phase = b64u_pkg::PH_0;
                enc_carry = 4'h0;
            end
            default: begin
                push_char(b64url_char(b[7:2]), 1'b0);
                if (eom) begin
                    push_char(b64url_char({b[1:0], 4'h0}), 1'b0);
                    push_char(ASC_PAD, 1'b0);
                    push_char(ASC_PAD, 1'b1);
                    enc_phase = b64u_pkg::PH_0;
                    enc_carry = 4'h0;
                end else begin
                    enc_phase = b64u_pkg::PH_1;
                    enc_carry = {2'b00, b[1:0]};
                end
            end
        endcase
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic eom);
        t_msg_byte m;
        m.data = b;
        m.eom  = eom;
        msg_byte_q.push_back(m);
    endtask

    // Sender: bursts of random length with random gaps; prediction on each input transfer.
    always @(posedge i_clk) begin
        logic      take;
        t_msg_byte nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            take = s_axis_tvalid && s_axis_tready;
            if (take) begin
                encode_byte(s_axis_tdata, s_axis_tlast);
                bytes_in <= bytes_in + 1;
            end
            if (!s_axis_tvalid || take) begin
                if (gap_left != 0 || msg_byte_q.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                    if (gap_left != 0) gap_left <= gap_left - 1;
                end else begin
                    nxt = msg_byte_q.pop_front();
                    s_axis_tdata  <= nxt.data;
                    s_axis_tlast  <= nxt.eom;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // Receiver: stall pattern redrawn at random from four modes; one long hold-off to back up the input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            rx_cyc <= rx_cyc + 1;
            if (rx_cyc % 128 == 127) rx_mode <= t_rx_mode'($urandom_range(0, 3));
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
                hold_left     <= hold_left - 1;
            end else if (!hold_done && bytes_in >= HOLD_AFTER) begin
                hold_done     <= 1'b1;
                hold_left     <= HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  m_axis_tready <= 1'b1;
                    RX_RANDOM:  m_axis_tready <= $urandom_range(0, 1);
                    RX_SPARSE:  m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:    m_axis_tready <= (rx_cyc % 5 != 2) && (rx_cyc % 7 != 4);
                endcase
            end
        end
    end

    // Output checker
    always @(posedge i_clk) begin
        t_enc_char e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (enc_char_q.size() == 0) begin
                $error("unexpected transfer: out_char %h final_char %b",
                       m_axis_tdata, m_axis_tlast);
                err_cnt++;
            end else begin
                e = enc_char_q.pop_front();
                if (m_axis_tdata !== e.ch) begin
                    $error("out_char: expected %h, actual %h", e.ch, m_axis_tdata);
                    err_cnt++;
                end
                if (m_axis_tlast !== e.fin) begin
                    $error("final_char: expected %b, actual %b", e.fin, m_axis_tlast);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int       n_rand;
        int       len;
        logic [7:0] v;

        // Directed: one-, two- and three-byte tails, all-zero/all-one bytes, '-' and '_'
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFB, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFB, 1'b0);
        queue_byte(8'hEF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h4D, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h6E, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'hFE, 1'b1);

        // Random messages, mostly short, a few long
        n_rand = 0;
        while (n_rand < N_RANDOM_BYTES) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 7) == 0)
                    v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                else
                    v = 8'($urandom_range(0, 255));
                queue_byte(v, k == len - 1);
            end
            n_rand += len;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (msg_byte_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (enc_char_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* base64url_stream_encoder.f */
rtl/core/b64u_pkg.sv
rtl/core/b64u_front.sv
rtl/core/b64u_queue.sv
rtl/core/b64u_back.sv
rtl/core/base64url_stream_encoder.sv
tb/sv/tb_base64url_stream_encoder.sv
